// ===== hdl/shds_pkg.sv =====
// shared types and constants for the sliding hamming distance sum block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package shds_pkg;

  localparam int unsigned EntryW  = 13;
  localparam int unsigned PlenW   = 13;
  localparam int unsigned AccW    = 23;
  localparam int unsigned PidxW   = 14;
  localparam logic [PidxW-1:0] PidxSat = 14'd8192;
  localparam logic [AccW-1:0]  AccMax  = {AccW{1'b1}};

  localparam logic ModeText    = 1'b0;
  localparam logic ModePattern = 1'b1;

  typedef struct packed {
    logic mode;
    logic bit_value;
    logic last;
  } in_item_t;

  typedef struct packed {
    logic [AccW-1:0] distance_sum;
    logic            error;
  } out_item_t;

  typedef struct packed {
    logic text_wr;
    logic pat_rd;
    logic diff_en;
    logic acc_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic item_mode;
    logic last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/sliding_hamming_distance_sum_top.sv =====
// top level of the sliding hamming distance sum block
// input channel: in_valid_i / in_stall_o carrying in_item_i (mode, bit_value, last)
// output channel: out_valid_o / out_stall_i carrying out_item_o (distance_sum, error)
// config channel: cfg_valid_i / cfg_ready_o with cfg_data_i = pattern length, always ready
// text items (mode 0) are each one write of the prefix-ones memory and do not stall the input
// pattern items (mode 1) run in steps: dual-port memory read, window diff, accumulate
// the last pattern item adds a result step that loads the output register;
// a job's result is the only output item
// MAX_LEN sets the memory depth; text beyond it is dropped and flagged as error
// after reset the counters and accumulator are clear and the pattern length is 1;
// the memory needs no clearing, only entries written by the current job are read
// a stalled result holds in the output register; a following text or pattern item is
// still taken, only a new result waits until the register is free
// depends on shds_pkg, shds_ctrl, shds_dp
`timescale 1ns / 1ps
`default_nettype none

module sliding_hamming_distance_sum_top #(
  parameter int unsigned MAX_LEN = 4096
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  shds_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output shds_pkg::out_item_t out_item_o,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire [12:0]          cfg_data_i
);
  import shds_pkg::*;

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready_o = 1'b1;

  shds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  shds_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire

// ===== hdl/shds_ctrl.sv =====
// controller state machine: sequences text writes and pattern read, diff, accumulate, result
// depends on shds_pkg
`timescale 1ns / 1ps
`default_nettype none

module shds_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  shds_pkg::status_t sts_i,
  output shds_pkg::cmd_t    cmd_o
);
  import shds_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StDiff  = 2'd1;
  localparam logic [1:0] StAccum = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       idle;

  assign idle       = (state_q == StIdle);
  assign in_stall_o = !idle;

  always_comb begin
    cmd_o          = '0;
    cmd_o.text_wr  = idle && in_valid_i && (sts_i.item_mode == ModeText);
    cmd_o.pat_rd   = idle && in_valid_i && (sts_i.item_mode == ModePattern);
    cmd_o.diff_en  = (state_q == StDiff);
    cmd_o.acc_en   = (state_q == StAccum);
    cmd_o.out_load = (state_q == StDone) && sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (cmd_o.pat_rd) state_d = StDiff;
      end
      StDiff: begin
        state_d = StAccum;
      end
      StAccum: begin
        state_d = sts_i.last ? StDone : StIdle;
      end
      StDone: begin
        if (sts_i.out_free) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  a_rd_then_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pat_rd |=> cmd_o.diff_en)
    else $error("pattern read not followed by diff");

  a_diff_then_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.diff_en |=> cmd_o.acc_en)
    else $error("diff not followed by accumulate");

  a_last_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.acc_en && sts_i.last) |=> (state_q == StDone))
    else $error("last pattern item did not reach result state");

  a_no_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.text_wr && (cmd_o.diff_en || cmd_o.acc_en || cmd_o.out_load)))
    else $error("text write overlaps pattern work");

endmodule

`default_nettype wire

// ===== hdl/shds_dp.sv =====
// datapath: prefix-ones memory, counters, accumulator, config register, output register
// depends on shds_pkg; driven by shds_ctrl commands
`timescale 1ns / 1ps
`default_nettype none

module shds_dp #(
  parameter int unsigned MAX_LEN = 4096
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  shds_pkg::in_item_t  in_item_i,
  input  wire                 cfg_we_i,
  input  wire [12:0]          cfg_data_i,
  input  shds_pkg::cmd_t      cmd_i,
  output shds_pkg::status_t   sts_o,
  output logic                out_valid_o,
  output shds_pkg::out_item_t out_item_o,
  input  wire                 out_stall_i
);
  import shds_pkg::*;

  localparam int unsigned AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned NW   = $clog2(MAX_LEN + 1);
  localparam int unsigned CW   = ((NW > PidxW) ? NW : PidxW) + 1;
  localparam int unsigned AddW = (NW > EntryW) ? NW : EntryW;

  logic [EntryW-1:0] mem [MAX_LEN];

  logic [PlenW-1:0]  plen_q;
  logic [NW-1:0]     tcnt_q;
  logic [PidxW-1:0]  pidx_q;
  logic [AccW-1:0]   acc_q;
  logic              ovf_q;
  logic [EntryW-1:0] ones_q;
  logic              bit_q, last_q, ok_q, lo_zero_q;
  logic [EntryW-1:0] rd_hi_q, rd_lo_q;
  logic [AddW-1:0]   add_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [CW-1:0]     n_ext, m_ext, i_ext, hi_sum, lo_sum, span_full;
  logic [AW-1:0]     hi_addr, lo_addr, wr_addr;
  logic              text_room, ok_d, err;
  logic [EntryW-1:0] ones_d, win_ones;
  logic [AddW-1:0]   span, add_d;
  logic [AccW:0]     sum;
  logic              out_free;

  assign n_ext     = CW'(tcnt_q);
  assign m_ext     = CW'(plen_q);
  assign i_ext     = CW'(pidx_q);
  assign hi_sum    = i_ext + n_ext - m_ext;
  assign lo_sum    = i_ext - CW'(1);
  assign hi_addr   = hi_sum[AW-1:0];
  assign lo_addr   = lo_sum[AW-1:0];
  assign wr_addr   = tcnt_q[AW-1:0];
  assign text_room = (tcnt_q < NW'(MAX_LEN));
  assign ones_d    = ones_q + EntryW'(in_item_i.bit_value);
  assign ok_d      = (plen_q != '0) && (m_ext <= n_ext) && (i_ext < m_ext);

  assign span_full = n_ext - m_ext + CW'(1);
  assign span      = AddW'(span_full[NW-1:0]);
  assign win_ones  = rd_hi_q - (lo_zero_q ? '0 : rd_lo_q);
  assign add_d     = bit_q ? (span - AddW'(win_ones)) : AddW'(win_ones);

  assign sum = {1'b0, acc_q} + (AccW+1)'(add_q);
  assign err = ovf_q || (plen_q == '0) || (m_ext > n_ext) || (i_ext != m_ext);

  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.item_mode = in_item_i.mode;
  assign sts_o.last      = last_q;
  assign sts_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.text_wr && text_room) begin
      mem[wr_addr] <= ones_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pat_rd) begin
      rd_hi_q <= mem[hi_addr];
      rd_lo_q <= mem[lo_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pat_rd) begin
      bit_q     <= in_item_i.bit_value;
      ok_q      <= ok_d;
      lo_zero_q <= (pidx_q == '0);
    end
    if (cmd_i.diff_en) begin
      add_q <= add_d;
    end
    if (cmd_i.out_load) begin
      out_q.distance_sum <= err ? '0 : acc_q;
      out_q.error        <= err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q      <= PlenW'(1);
      tcnt_q      <= '0;
      pidx_q      <= '0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      ones_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) plen_q <= cfg_data_i;
      if (cmd_i.text_wr) begin
        if (text_room) begin
          tcnt_q <= tcnt_q + NW'(1);
          ones_q <= ones_d;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.pat_rd) begin
        last_q <= in_item_i.last;
        if (pidx_q < PidxSat) pidx_q <= pidx_q + PidxW'(1);
      end
      if (cmd_i.acc_en && ok_q) begin
        acc_q <= sum[AccW] ? AccMax : sum[AccW-1:0];
      end
      if (cmd_i.out_load) begin
        tcnt_q <= '0;
        pidx_q <= '0;
        acc_q  <= '0;
        ovf_q  <= 1'b0;
        ones_q <= '0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== bench/sliding_hamming_distance_sum_top_test.sv =====
// self-checking testbench for sliding_hamming_distance_sum_top: directed table and random jobs
// predicts every job's distance sum in place and checks each result item as it leaves the block
// depends on shds_pkg and sliding_hamming_distance_sum_top
`timescale 1ns / 1ps

module sliding_hamming_distance_sum_top_test;
  import shds_pkg::*;

  localparam int unsigned MaxLen      = 4096;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned BusyCycles  = 8;
  localparam int unsigned RandomItems = 1380;
  localparam int unsigned DirRows     = 27;

  typedef enum bit {RowItem, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [PlenW-1:0]  len;
    in_item_t          item;
    bit                typed;
    out_item_t         res;
  } stim_row_t;

  localparam stim_row_t DirTable [DirRows] = '{
    '{RowItem, 13'd0,    '{ModePattern, 1'b1, 1'b1}, 1'b1, '{23'd0, 1'b1}},
    '{RowItem, 13'd0,    '{ModeText,    1'b1, 1'b0}, 1'b0, '{23'd0, 1'b0}},
    '{RowItem, 13'd0,    '{ModeText,    1'b0, 1'b1}, 1'b0, '{23'd0, 1'b0}},
    '{RowItem, 13'd0,    '{ModeText,    1'b1, 1'b0}, 1'b0, '{23'd0, 1'b0}},
    '{RowItem, 13'd0,    '{ModePattern, 1'b0, 1'b1}, 1'b1, '{23'd2, 1'b0}},
    '{RowItem, 13'd0,    '{ModeText,    1'b1, 1'b0}, 1'b0, '{23'd0, 1'b0}},
    '{RowItem, 13'd0,    '{ModePattern, 1'b1, 1'b0}, 1'b0, '{23'd0, 1'b0}},
    '{RowItem, 13'd0,    '{ModePattern, 1'b0, 1'b1}, 1'b1, '{23'd0, 1'b1}},
    '{RowCfg,  13'd0,    '{ModeText,    1'b0, 1'b0}, 1'b0, '{23'd0, 1'b0}},
    '{RowItem, 13'd0,    '{ModeText,    1'b1, 1'b0}, 1'b0, '{23'd0, 1'b0}},
    '{RowItem, 13'd0,    '{ModePattern, 1'b1, 1'b1}, 1'b1, '{23'd0, 1'b1}},
    '{RowCfg,  13'd3,    '{ModeText,    1'b0, 1'b0}, 1'b0, '{23'd0, 1'b0}},
    '{RowItem, 13'd0,    '{ModeText,    1'b0, 1'b0}, 1'b0, '{23'd0, 1'b0}},
    '{RowItem, 13'd0,    '{ModeText,    1'b1, 1'b0}, 1'b0, '{23'd0, 1'b0}},
    '{RowItem, 13'd0,    '{ModePattern, 1'b1, 1'b0}, 1'b0, '{23'd0, 1'b0}},
    '{RowItem, 13'd0,    '{ModeText,    1'b1, 1'b0}, 1'b0, '{23'd0, 1'b0}},
    '{RowItem, 13'd0,    '{ModeText,    1'b0, 1'b0}, 1'b0, '{23'd0, 1'b0}},
    '{RowItem, 13'd0,    '{ModePattern, 1'b0, 1'b0}, 1'b0, '{23'd0, 1'b0}},
    '{RowItem, 13'd0,    '{ModePattern, 1'b1, 1'b1}, 1'b0, '{23'd0, 1'b0}},
    '{RowCfg,  13'd8191, '{ModeText,    1'b0, 1'b0}, 1'b0, '{23'd0, 1'b0}},
    '{RowItem, 13'd0,    '{ModeText,    1'b1, 1'b0}, 1'b0, '{23'd0, 1'b0}},
    '{RowItem, 13'd0,    '{ModePattern, 1'b0, 1'b1}, 1'b1, '{23'd0, 1'b1}},
    '{RowCfg,  13'd2,    '{ModeText,    1'b0, 1'b0}, 1'b0, '{23'd0, 1'b0}},
    '{RowItem, 13'd0,    '{ModeText,    1'b0, 1'b0}, 1'b0, '{23'd0, 1'b0}},
    '{RowItem, 13'd0,    '{ModeText,    1'b0, 1'b0}, 1'b0, '{23'd0, 1'b0}},
    '{RowItem, 13'd0,    '{ModePattern, 1'b1, 1'b0}, 1'b0, '{23'd0, 1'b0}},
    '{RowItem, 13'd0,    '{ModePattern, 1'b1, 1'b1}, 1'b1, '{23'd2, 1'b0}}
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_item = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [PlenW-1:0] cfg_data = '0;

  int unsigned tx_idle_pct = 7;
  int unsigned rx_idle_pct = 87;
  int unsigned items_sent = 0;
  int unsigned fail_count = 0;

  // predictor state
  logic [EntryW-1:0] ones_upto [MaxLen];
  int unsigned       text_len = 0;
  int unsigned       pat_taken = 0;
  logic [AccW-1:0]   dist_acc = '0;
  bit                text_overflow = 1'b0;
  logic [PlenW-1:0]  pat_len = 13'd1;
  out_item_t         expected_sums [$];

  sliding_hamming_distance_sum_top #(.MAX_LEN(MaxLen)) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // ones among the first j text bits
  function automatic int unsigned ones_in_first(input int unsigned j);
    if (j == 0 || j > MaxLen) return 0;
    return ones_upto[j-1];
  endfunction

  function automatic bit advance_distance(input in_item_t it, output out_item_t res);
    int unsigned n, m, i, span, ones, add, sum;
    bit err;
    n = text_len;
    m = pat_len;
    res = '0;
    if (it.mode == ModeText) begin
      if (n >= MaxLen) begin
        text_overflow = 1'b1;
      end else begin
        ones_upto[n] = EntryW'(ones_in_first(n) + it.bit_value);
        text_len = n + 1;
      end
      return 1'b0;
    end
    i = pat_taken;
    if (m >= 1 && m <= n && i < m) begin
      span = n - m + 1;
      ones = (ones_in_first(i + span) - ones_in_first(i)) & 32'h1fff;
      add = it.bit_value ? span - ones : ones;
      sum = dist_acc + add;
      dist_acc = (sum > AccMax) ? AccMax : AccW'(sum);
    end
    if (i < PidxSat) pat_taken = i + 1;
    if (!it.last) return 1'b0;
    err = text_overflow || m == 0 || m > n || pat_taken != m;
    res.distance_sum = err ? '0 : dist_acc;
    res.error = err;
    text_len = 0;
    pat_taken = 0;
    dist_acc = '0;
    text_overflow = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (advance_distance(it, res)) begin
      expected_sums.insert(expected_sums.size(), typed ? typed_res : res);
    end
  endtask

  task automatic set_pattern_length(input logic [PlenW-1:0] len);
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (BusyCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pat_len = len;
  endtask

  // text bits first unless mixed; the final item is always the last pattern bit
  task automatic send_job(input int unsigned n_text, input int unsigned n_pat, input bit mixed);
    in_item_t it;
    int unsigned t, p;
    t = n_text;
    p = n_pat;
    while (t + p != 0) begin
      it.bit_value = 1'($urandom_range(1));
      if (t != 0 && (!mixed || p <= 1 || $urandom_range(1) == 1)) begin
        it.mode = ModeText;
        it.last = ($urandom_range(9) == 0);
        t--;
      end else begin
        it.mode = ModePattern;
        it.last = (p == 1);
        p--;
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic run_random_job();
    int unsigned m, n, np, pick;
    m = pat_len;
    pick = $urandom_range(9);
    n = (m > 40) ? $urandom_range(40, 1) : m + $urandom_range(20);
    np = (m == 0 || m > 40) ? $urandom_range(3, 1) : m;
    if (pick == 7) np = (np > 1 && $urandom_range(1) == 1) ? np - 1 : np + 1;
    if (pick == 8 && m != 0 && m <= 40) n = $urandom_range(m - 1);
    send_job(n, np, pick == 9);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected result item: expected none, got sum %0d error %0b",
                 $time, out_item.distance_sum, out_item.error);
        fail_count++;
      end else begin
        want = expected_sums.pop_front();
        if (out_item.distance_sum !== want.distance_sum) begin
          $display("%0t: distance_sum mismatch: expected %0d, got %0d",
                   $time, want.distance_sum, out_item.distance_sum);
          fail_count++;
        end
        if (out_item.error !== want.error) begin
          $display("%0t: error flag mismatch: expected %0b, got %0b",
                   $time, want.error, out_item.error);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)
                     || (cfg_valid && cfg_ready))) begin
        quiet++;
      end else begin
        quiet = 0;
      end
    end
    $display("sliding_hamming_distance_sum_top verification failed");
    $finish;
  end

  initial begin
    int unsigned phase, stop, pick;
    logic [PlenW-1:0] len;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DirRows; r++) begin
      if (DirTable[r].kind == RowCfg) begin
        set_pattern_length(DirTable[r].len);
      end else begin
        send_item(DirTable[r].item, DirTable[r].typed, DirTable[r].res);
      end
    end

    // one longer job with a wide sliding span
    set_pattern_length(13'd64);
    send_job(192, 64, 1'b0);

    for (phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 87 : 0;
      rx_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 7 : 0;
      stop = items_sent + RandomItems / 3;
      while (items_sent < stop) begin
        if ($urandom_range(3) == 0) begin
          pick = $urandom_range(19);
          if (pick == 0) len = '0;
          else if (pick == 1) len = '1;
          else if (pick == 2) len = PlenW'($urandom_range(40, 17));
          else len = PlenW'($urandom_range(16, 1));
          set_pattern_length(len);
        end
        run_random_job();
      end
    end
    in_valid <= 1'b0;

    while (expected_sums.size() != 0) @(posedge clk);
    repeat (2 * BusyCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("sliding_hamming_distance_sum_top verification clean");
    end else begin
      $display("sliding_hamming_distance_sum_top verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/shds_pkg.sv
hdl/shds_ctrl.sv
hdl/shds_dp.sv
hdl/sliding_hamming_distance_sum_top.sv
bench/sliding_hamming_distance_sum_top_test.sv
